/* rtl/ilist_pkg.sv */
// ----------------------------------------------------------------------------
// ilist_pkg
// Shared constants and codes for the indexed list block: capacity, field
// widths, operation codes and status codes.
// ----------------------------------------------------------------------------
package ilist_pkg;

   // list storage
   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int LEN_W    = 11;

   // field widths
   localparam int OP_W     = 3;
   localparam int POS_W    = 11;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // stream beat widths (tdata rounded up to whole bytes)
   localparam int REQ_FIELDS_W = POS_W + VALUE_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = VALUE_W + STATUS_W + LEN_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // operation codes
   localparam logic [OP_W-1:0] OP_READ    = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_HD  = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_TL  = 3'd2;
   localparam logic [OP_W-1:0] OP_INS_POS = 3'd3;
   localparam logic [OP_W-1:0] OP_DELETE  = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [LEN_W-1:0]   len_type;
   typedef logic [VALUE_W-1:0] value_type;

endpackage

/* rtl/indexed_list_insert_delete.sv */
// Sequence: a rejected request or a delete of the tail goes straight to
//   the response; a read waits for the RAM read data; an append writes the
//   value; an insert before p shifts elements p..length-1 up, then writes;
//   a delete at p shifts elements p+1..length-1 down. A stalled response
//   holds the block until it is taken. One request at a time.
// Reset: synchronous; clears the length and control state, not the RAM.
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// Ordered list of 32-bit values kept in one RAM, with read, insert at
// head, tail or position, and delete by position. Shifts run as a pipelined
// read-modify-write over the RAM.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete (
   input  logic                               clock,
   input  logic                               reset,
   // request: tuser = op[2:0]
   //          tdata = position[10:0], value_in[42:11], zero pad[47:43]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ilist_pkg::OP_W-1:0]         req_tuser,
   input  logic [ilist_pkg::REQ_DATA_W-1:0]   req_tdata,
   // response: tdata = value_out[31:0], status[33:32], length[44:34],
   //           zero pad[47:45]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ilist_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   import ilist_pkg::*;

   // state codes
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_LAST  = 3'd3;
   localparam logic [2:0] S_FILL  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   // response value select
   localparam logic [1:0] VS_ZERO = 2'd0;
   localparam logic [1:0] VS_MEM  = 2'd1;
   localparam logic [1:0] VS_NEG  = 2'd2;

   // length update
   localparam logic [1:0] LU_KEEP = 2'd0;
   localparam logic [1:0] LU_INC  = 2'd1;
   localparam logic [1:0] LU_DEC  = 2'd2;

   logic [2:0]          state_ff, state_in;
   len_type             len_ff, len_in;
   addr_type            ptr_ff, ptr_in;
   addr_type            stop_ff, stop_in;
   logic                grow_ff, grow_in;
   addr_type            pos_ff, pos_in;
   value_type           val_ff, val_in;
   logic                wr_pend_ff, wr_pend_in;
   addr_type            wr_addr_ff, wr_addr_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [1:0]          vsel_ff, vsel_in;
   logic [1:0]          lupd_ff, lupd_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // RAM ports
   logic      ram_we;
   addr_type  ram_waddr;
   value_type ram_wdata;
   logic      ram_re;
   addr_type  ram_raddr;
   value_type ram_rdata;

   // request fields
   logic [OP_W-1:0]  req_op;
   logic [POS_W-1:0] req_pos;
   value_type        req_val;
   len_type          len_m1;
   len_type          pos_p1;
   len_type          eff_pos;
   logic             full;
   logic             rsp_free;
   len_type          len_new;
   value_type        value_res;

   assign req_op  = req_tuser;
   assign req_pos = req_tdata[POS_W-1:0];
   assign req_val = req_tdata[POS_W +: VALUE_W];
   assign len_m1  = len_ff - LEN_W'(1);
   assign pos_p1  = req_pos + LEN_W'(1);
   assign full    = (len_ff == LEN_W'(CAPACITY));
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // element store
   ilist_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // drive RAM ports from the sequencer state
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = wr_addr_ff;
      ram_wdata = ram_rdata;
      ram_re    = 1'b0;
      ram_raddr = ptr_ff;
      case (state_ff)
         S_READ: begin
            ram_re    = 1'b1;
            ram_raddr = pos_ff;
         end
         S_SHIFT: begin
            ram_re = 1'b1;
            ram_we = wr_pend_ff;
         end
         S_LAST: begin
            ram_we = wr_pend_ff;
         end
         S_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff;
            ram_wdata = val_ff;
         end
         default: begin
         end
      endcase
   end

   // result value and new length
   always_comb begin
      case (vsel_ff)
         VS_MEM:  value_res = ram_rdata;
         VS_NEG:  value_res = '1;
         default: value_res = '0;
      endcase
      case (lupd_ff)
         LU_INC:  len_new = len_ff + LEN_W'(1);
         LU_DEC:  len_new = len_m1;
         default: len_new = len_ff;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      ptr_in       = ptr_ff;
      stop_in      = stop_ff;
      grow_in      = grow_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      wr_pend_in   = wr_pend_ff;
      wr_addr_in   = wr_addr_ff;
      status_in    = status_ff;
      vsel_in      = vsel_ff;
      lupd_in      = lupd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      eff_pos      = req_pos;

      case (state_ff)
         // decode a request beat
         S_IDLE: begin
            if (req_tvalid) begin
               val_in     = req_val;
               wr_pend_in = 1'b0;
               status_in  = ST_DONE;
               vsel_in    = VS_ZERO;
               lupd_in    = LU_KEEP;
               state_in   = S_DONE;
               case (req_op)
                  OP_READ: begin
                     if (req_pos < len_ff) begin
                        pos_in   = req_pos[ADDR_W-1:0];
                        vsel_in  = VS_MEM;
                        state_in = S_READ;
                     end else begin
                        status_in = ST_RANGE;
                        vsel_in   = VS_NEG;
                     end
                  end
                  OP_INS_HD, OP_INS_TL, OP_INS_POS: begin
                     if (req_op == OP_INS_HD) begin
                        eff_pos = '0;
                     end else if (req_op == OP_INS_TL) begin
                        eff_pos = len_ff;
                     end
                     if (eff_pos > len_ff) begin
                        status_in = ST_RANGE;
                     end else if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        pos_in  = eff_pos[ADDR_W-1:0];
                        lupd_in = LU_INC;
                        grow_in = 1'b1;
                        ptr_in  = len_m1[ADDR_W-1:0];
                        stop_in = eff_pos[ADDR_W-1:0];
                        state_in = (eff_pos == len_ff) ? S_FILL : S_SHIFT;
                     end
                  end
                  OP_DELETE: begin
                     if (req_pos < len_ff) begin
                        lupd_in = LU_DEC;
                        grow_in = 1'b0;
                        ptr_in  = pos_p1[ADDR_W-1:0];
                        stop_in = len_m1[ADDR_W-1:0];
                        if (pos_p1 != len_ff) begin
                           state_in = S_SHIFT;
                        end
                     end else begin
                        status_in = ST_RANGE;
                     end
                  end
                  default: begin
                     status_in = ST_RANGE;
                  end
               endcase
            end
         end
         // wait for read data
         S_READ: begin
            state_in = S_DONE;
         end
         // read one element, write the one read last cycle
         S_SHIFT: begin
            wr_pend_in = 1'b1;
            wr_addr_in = grow_ff ? (ptr_ff + ADDR_W'(1)) : (ptr_ff - ADDR_W'(1));
            if (ptr_ff == stop_ff) begin
               state_in = S_LAST;
            end else begin
               ptr_in = grow_ff ? (ptr_ff - ADDR_W'(1)) : (ptr_ff + ADDR_W'(1));
            end
         end
         // drain the final moved element
         S_LAST: begin
            wr_pend_in = 1'b0;
            state_in   = grow_ff ? S_FILL : S_DONE;
         end
         // write the new value into the gap
         S_FILL: begin
            state_in = S_DONE;
         end
         // hand the result to the output register
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({len_new, status_ff, value_res});
               len_in       = len_new;
               lupd_in      = LU_KEEP;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         lupd_ff      <= LU_KEEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         wr_pend_ff   <= wr_pend_in;
         lupd_ff      <= lupd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      stop_ff     <= stop_in;
      grow_ff     <= grow_in;
      pos_ff      <= pos_in;
      val_ff      <= val_in;
      wr_addr_ff  <= wr_addr_in;
      status_ff   <= status_in;
      vsel_ff     <= vsel_in;
      rsp_data_ff <= rsp_data_in;
   end

   // length never passes capacity
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(CAPACITY))
      else $error("list length above capacity");

   // fill never collides with a pending shift write
   a_fill_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |-> !wr_pend_ff)
      else $error("fill write collides with shift write");

   // shift read never hits the entry being written
   a_shift_no_alias: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && wr_pend_ff) |-> (ptr_ff != wr_addr_ff))
      else $error("shift read aliases pending write");

   // insert only into a list with room
   a_fill_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |-> (len_ff < LEN_W'(CAPACITY)))
      else $error("insert into full list");

endmodule

/* rtl/ilist_ram.sv */
// ----------------------------------------------------------------------------
// ilist_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. Read data holds while idle.
// ----------------------------------------------------------------------------
module ilist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
